@@ rtl/cif_pkg.sv @@
// Shared types, sizes and codes for the 3x3 image convolution filter.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package cif_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int MAX_WIDTH = 2048;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 13;
	// Draining runs the row position up to one past the height, so it needs an extra bit.
	localparam int ROW_W = HEIGHT_W + 1;
	localparam int CH_W = 2;

	localparam int LS_DEPTH = MAX_WIDTH * 3;
	localparam int LS_ADDR_W = $clog2(LS_DEPTH);

	// Blur divides the nine-sample sum by nine with a rounded-up reciprocal.
	localparam int SUM_W = SAMPLE_BITS + 4;
	localparam int LAP_W = SAMPLE_BITS + 4;
	localparam int RECIP_SHIFT = SUM_W + 4;
	localparam int RECIP_W = RECIP_SHIFT - 3;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT + 8) / 9);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 3'd4;

	localparam logic [1:0] MODE_BLUR = 2'd0;
	localparam logic [1:0] MODE_LAPLACE = 2'd1;
	localparam logic [1:0] MODE_SHARPEN = 2'd2;
	localparam logic [1:0] MODE_ZERO = 2'd3;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_RST = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [15:0] MAX_VALUE_RST = 16'd255;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic req_type;
		logic [FIELD_BITS-1:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] filtered_value;
		logic frame_last;
	} out_item_t;

	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
	} col_t;

	typedef struct packed {
		col_t left;
		col_t center;
		col_t right;
	} win_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} win_mask_t;

	typedef struct packed {
		sample_t upper;
		sample_t middle;
	} ls_word_t;

endpackage

`default_nettype wire

@@ rtl/conv3x3_image_filter.sv @@
// Streaming 3x3 convolution filter (blur, Laplacian, sharpen, zero) over gray or RGB rasters.
// Throughput: one transaction per cycle unless out_ready stalls. The transaction that completes
// a window passes stage 1 (line store read, window), three kernel stages, the output register.
// Reset: configuration returns to 640x480, max 255, blur, gray; frame position returns to zero.
// Line store contents are not cleared; border masking keeps stale rows out of results.
// Depends on cif_pkg, cif_line_store, cif_window and cif_kernel.
`default_nettype none

module conv3x3_image_filter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  cif_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output cif_pkg::out_item_t                out_data,
	input  wire logic                         cfg_we,
	input  wire logic [cif_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [cif_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cif_pkg::*;

	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [15:0] max_q;
	logic [1:0] mode_q;
	logic color_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CH_W-1:0] chan_q;

	logic [WIDTH_W-1:0] cfg_width;
	logic [HEIGHT_W-1:0] cfg_height;
	logic cfg_hit;

	logic rx0, row_ge1, row_ge2, row_ge3, row_lt_h, row_le_h, row_end;
	logic chan_end, col_end, act, take, emit_a, last_a;
	win_mask_t mask_a;
	sample_t sample_a;
	logic [LS_ADDR_W-1:0] addr_a;

	logic v_s1, emit_s1, last_s1;
	win_mask_t mask_s1;
	sample_t sample_s1;
	logic [CH_W-1:0] chan_s1;
	logic [LS_ADDR_W-1:0] addr_s1;
	logic done_s1, k_ready;

	ls_word_t ls_rd, ls_wr;
	col_t new_col;
	win_t win;

	// Configuration: width and height are stored already limited to their usable range.
	always_comb begin
		cfg_width = cfg_data[WIDTH_W-1:0];
		if (cfg_width == '0) begin
			cfg_width = WIDTH_W'(1);
		end else if (cfg_width > WIDTH_W'(MAX_WIDTH)) begin
			cfg_width = WIDTH_W'(MAX_WIDTH);
		end
		cfg_height = cfg_data[HEIGHT_W-1:0];
		if (cfg_height == '0) begin
			cfg_height = HEIGHT_W'(1);
		end
		cfg_hit = cfg_we && (cfg_idx == CFG_FRAME_WIDTH || cfg_idx == CFG_FRAME_HEIGHT
			|| cfg_idx == CFG_MAX_VALUE || cfg_idx == CFG_FILTER_MODE
			|| cfg_idx == CFG_COLOR_MODE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			max_q <= MAX_VALUE_RST;
			mode_q <= MODE_BLUR;
			color_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FRAME_WIDTH: width_q <= cfg_width;
				CFG_FRAME_HEIGHT: height_q <= cfg_height;
				CFG_MAX_VALUE: max_q <= cfg_data[15:0];
				CFG_FILTER_MODE: mode_q <= cfg_data[1:0];
				CFG_COLOR_MODE: color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Position decode. The result of a transaction is for the pixel one row plus one
	// pixel behind; at the start of a row it is the last pixel of the row before.
	always_comb begin
		rx0 = (col_q == '0);
		row_ge1 = (row_q != '0);
		row_ge2 = (row_q >= ROW_W'(2));
		row_ge3 = (row_q >= ROW_W'(3));
		row_lt_h = (row_q < ROW_W'(height_q));
		row_le_h = (row_q <= ROW_W'(height_q));
		row_end = (row_q == ROW_W'(height_q) + ROW_W'(1));
		chan_end = (chan_q == (color_q ? CH_W'(2) : CH_W'(0)));
		col_end = ((WIDTH_W'(col_q) + WIDTH_W'(1)) == width_q);
		act = (in_data.req_type == REQ_PUSH) ? row_lt_h : !row_lt_h;
		take = in_valid && in_ready && act;
		emit_a = rx0 ? row_ge2 : row_ge1;
		mask_a.top_ok = rx0 ? row_ge3 : row_ge2;
		mask_a.bot_ok = rx0 ? row_le_h : row_lt_h;
		mask_a.left_ok = rx0 ? (width_q != WIDTH_W'(1)) : (col_q[COL_W-1:1] != '0);
		mask_a.right_ok = !rx0;
		last_a = rx0 && row_end && chan_end;
		sample_a = (in_data.req_type == REQ_PUSH) ? SAMPLE_BITS'(in_data.pixel_value) : '0;
		addr_a = LS_ADDR_W'({col_q, 1'b0}) + LS_ADDR_W'(col_q) + LS_ADDR_W'(chan_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
		end else if (cfg_hit || (take && last_a)) begin
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
		end else if (take) begin
			if (chan_end) begin
				chan_q <= '0;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else begin
				chan_q <= chan_q + CH_W'(1);
			end
		end
	end

	// Stage 1 waits for the line store read; items without a result leave here.
	assign done_s1 = v_s1 && (!emit_s1 || k_ready);
	assign in_ready = !v_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			emit_s1 <= emit_a;
			last_s1 <= last_a;
			mask_s1 <= mask_a;
			sample_s1 <= sample_a;
			chan_s1 <= chan_q;
			addr_s1 <= addr_a;
		end
	end

	assign ls_wr.upper = ls_rd.middle;
	assign ls_wr.middle = sample_s1;

	cif_line_store u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (addr_a),
		.wr_en   (done_s1),
		.wr_addr (addr_s1),
		.wr_data (ls_wr),
		.rd_data (ls_rd)
	);

	assign new_col.top = ls_rd.upper;
	assign new_col.mid = ls_rd.middle;
	assign new_col.bot = sample_s1;

	cif_window u_window (
		.clk      (clk),
		.shift_en (done_s1),
		.chan     (chan_s1),
		.new_col  (new_col),
		.mask     (mask_s1),
		.win      (win)
	);

	cif_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1 && emit_s1),
		.in_ready  (k_ready),
		.win       (win),
		.in_last   (last_s1),
		.mode      (mode_q),
		.max_value (max_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_W'(height_q) + ROW_W'(1))
		else $error("row position ran past the drain row");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_a) |=> (col_q == '0 && row_q == '0 && chan_q == '0))
		else $error("frame position not cleared after the final sample");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && emit_s1 && !k_ready))
		else $error("input stalled without a blocked result in stage 1");

endmodule

`default_nettype wire

@@ rtl/cif_line_store.sv @@
// Two-row line store for the 3x3 filter: one word holds the upper and middle rows.
// Registered read with write-to-read bypass. Depends on cif_pkg.
`default_nettype none

module cif_line_store (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       rd_en,
	input  wire logic [cif_pkg::LS_ADDR_W-1:0] rd_addr,
	input  wire logic                       wr_en,
	input  wire logic [cif_pkg::LS_ADDR_W-1:0] wr_addr,
	input  cif_pkg::ls_word_t               wr_data,
	output cif_pkg::ls_word_t               rd_data
);
	import cif_pkg::*;

	ls_word_t mem [LS_DEPTH];
	ls_word_t rd_q;
	ls_word_t byp_data_q;
	logic byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// A write landing on the address being read in the same cycle wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

@@ rtl/cif_window.sv @@
// Per-channel 3x3 window columns and border masking for the filter.
// Holds the two most recent columns of each channel. Depends on cif_pkg.
`default_nettype none

module cif_window (
	input  wire logic                  clk,
	input  wire logic                  shift_en,
	input  wire logic [cif_pkg::CH_W-1:0] chan,
	input  cif_pkg::col_t              new_col,
	input  cif_pkg::win_mask_t         mask,
	output cif_pkg::win_t              win
);
	import cif_pkg::*;

	col_t col1_q [3];
	col_t col2_q [3];

	function automatic col_t mask_col(input col_t c, input logic keep, input win_mask_t m);
		col_t r;
		r.top = (keep && m.top_ok) ? c.top : '0;
		r.mid = keep ? c.mid : '0;
		r.bot = (keep && m.bot_ok) ? c.bot : '0;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col1_q[chan] <= col2_q[chan];
			col2_q[chan] <= new_col;
		end
	end

	// The center pixel is always the previous column of this channel; the
	// newest column is its right neighbor and exists only inside a row.
	always_comb begin
		win.left = mask_col(col1_q[chan], mask.left_ok, mask);
		win.center = mask_col(col2_q[chan], 1'b1, mask);
		win.right = mask_col(new_col, mask.right_ok, mask);
	end

endmodule

`default_nettype wire

@@ rtl/cif_kernel.sv @@
// Kernel arithmetic for the 3x3 filter: sums, divide by nine, clamp, output register.
// Three pipeline stages plus the output register. Depends on cif_pkg.
`default_nettype none

module cif_kernel (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  cif_pkg::win_t    win,
	input  wire logic        in_last,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] max_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output cif_pkg::out_item_t out_data
);
	import cif_pkg::*;

	logic v_s2, v_s3, v_s4;
	logic space_o, space4, space3;

	win_t win_s2;
	logic last_s2, last_s3, last_s4;
	logic [SUM_W-1:0] sum_s3;
	logic [LAP_W-1:0] lap_s3, lap_s4;
	sample_t quo_s4;

	logic [SUM_W-1:0] sum9, nb4, ctr4, ctr_k;
	logic [LAP_W-1:0] lap;
	logic [PROD_W-1:0] prod;
	logic [15:0] res;
	out_item_t out_q;
	logic out_valid_q;

	assign space_o = !out_valid_q || out_ready;
	assign space4 = !v_s4 || space_o;
	assign space3 = !v_s3 || space4;
	assign in_ready = !v_s2 || space3;

	always_comb begin
		sum9 = SUM_W'(win_s2.left.top) + SUM_W'(win_s2.left.mid) + SUM_W'(win_s2.left.bot)
			+ SUM_W'(win_s2.center.top) + SUM_W'(win_s2.center.mid)
			+ SUM_W'(win_s2.center.bot) + SUM_W'(win_s2.right.top)
			+ SUM_W'(win_s2.right.mid) + SUM_W'(win_s2.right.bot);
		nb4 = SUM_W'(win_s2.left.mid) + SUM_W'(win_s2.right.mid)
			+ SUM_W'(win_s2.center.top) + SUM_W'(win_s2.center.bot);
		ctr4 = SUM_W'(win_s2.center.mid) << 2;
		ctr_k = (mode == MODE_SHARPEN) ? ctr4 + SUM_W'(win_s2.center.mid) : ctr4;
		// The difference always fits, so the top bit serves as the sign.
		lap = LAP_W'(ctr_k - nb4);
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(RECIP);

	always_comb begin
		unique case (mode)
			MODE_BLUR: begin
				res = (16'(quo_s4) > max_value) ? max_value : 16'(quo_s4);
			end
			MODE_LAPLACE, MODE_SHARPEN: begin
				if (lap_s4[LAP_W-1]) begin
					res = '0;
				end else if (lap_s4[LAP_W-2:0] > (LAP_W-1)'(max_value)) begin
					res = max_value;
				end else begin
					res = 16'(lap_s4[LAP_W-2:0]);
				end
			end
			MODE_ZERO: begin
				res = '0;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (space3) begin
				v_s3 <= v_s2;
			end
			if (space4) begin
				v_s4 <= v_s3;
			end
			if (space_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			win_s2 <= win;
			last_s2 <= in_last;
		end
		if (space3 && v_s2) begin
			sum_s3 <= sum9;
			lap_s3 <= lap;
			last_s3 <= last_s2;
		end
		if (space4 && v_s3) begin
			quo_s4 <= prod[RECIP_SHIFT +: SAMPLE_BITS];
			lap_s4 <= lap_s3;
			last_s4 <= last_s3;
		end
		if (space_o && v_s4) begin
			out_q.filtered_value <= FIELD_BITS'(res);
			out_q.frame_last <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

@@ tb/sv/cif_filter_checker.sv @@
// Result checker for the 3x3 image convolution filter: predicts each output sample
// from the accepted input and register-write transactions and compares field by field.
// Depends on cif_pkg for the payload types, register indexes and mode codes.
`timescale 1ns / 100ps

module cif_filter_checker
	import cif_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  in_item_t                   in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         outstanding,
	output int                         checked
);

	// Neighborhood of one channel, indexed [column][row], left and top first.
	typedef logic [2:0][2:0][SAMPLE_BITS-1:0] patch_t;

	logic [WIDTH_W-1:0] reg_width;
	logic [HEIGHT_W-1:0] reg_height;
	logic [15:0] reg_max;
	logic [1:0] reg_mode;
	logic reg_color;

	sample_t row_older [LS_DEPTH];
	sample_t row_newer [LS_DEPTH];
	patch_t win [3];
	longint col_pos, row_pos, chan_pos;

	out_item_t expected_q [$];

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		chan_pos = 0;
	endfunction

	function automatic void clear_model();
		int i;
		reg_width = WIDTH_RST;
		reg_height = HEIGHT_RST;
		reg_max = MAX_VALUE_RST;
		reg_mode = MODE_BLUR;
		reg_color = 1'b0;
		for (i = 0; i < LS_DEPTH; i++) begin
			row_older[i] = '0;
			row_newer[i] = '0;
		end
		for (i = 0; i < 3; i++)
			win[i] = '0;
		restart_frame();
		expected_q.delete();
		outstanding = 0;
	endfunction

	function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_FRAME_WIDTH: reg_width = data[WIDTH_W-1:0];
			CFG_FRAME_HEIGHT: reg_height = data[HEIGHT_W-1:0];
			CFG_MAX_VALUE: reg_max = data[15:0];
			CFG_FILTER_MODE: reg_mode = data[1:0];
			CFG_COLOR_MODE: reg_color = data[0];
			default: return;
		endcase
		restart_frame();
	endfunction

	// Kernel centered on pixel (x, y); taps outside the frame read as zero.
	function automatic logic [FIELD_BITS-1:0] kernel_value(patch_t p, longint y, longint x,
			longint wd, longint ht);
		longint v [3][3];
		longint acc, cx, ry;
		int i, j;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				cx = x + i - 1;
				ry = y + j - 1;
				v[i][j] = (cx >= 0 && cx < wd && ry >= 0 && ry < ht) ? longint'(p[i][j]) : 0;
			end
		end
		case (reg_mode)
			MODE_BLUR: begin
				acc = 0;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						acc += v[i][j];
				acc = acc / 9;
			end
			MODE_LAPLACE: acc = 4 * v[1][1] - v[0][1] - v[2][1] - v[1][0] - v[1][2];
			MODE_SHARPEN: acc = 5 * v[1][1] - v[0][1] - v[2][1] - v[1][0] - v[1][2];
			default: acc = 0;
		endcase
		if (acc > longint'(reg_max))
			acc = longint'(reg_max);
		if (acc < 0)
			acc = 0;
		return acc[FIELD_BITS-1:0];
	endfunction

	function automatic void filter_step(in_item_t item);
		longint wd, ht, nch, rx, ry, c, s, lag, o;
		sample_t smp, up, mid;
		patch_t tail_patch;
		logic emit;
		logic [FIELD_BITS-1:0] val;
		out_item_t due;
		int slot;
		wd = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width);
		ht = (reg_height == 0) ? 1 : reg_height;
		nch = reg_color ? 3 : 1;
		rx = col_pos;
		ry = row_pos;
		c = chan_pos;
		if (item.req_type == REQ_PUSH) begin
			if (ry >= ht)
				return;
			smp = item.pixel_value[SAMPLE_BITS-1:0];
		end else begin
			if (ry < ht)
				return;
			smp = '0;
		end
		if (rx >= wd)
			rx = 0;
		if (c >= nch)
			c = 0;
		s = (ry * wd + rx) * nch + c;
		lag = (wd + 1) * nch;
		emit = 1'b0;
		val = '0;

		// A row start finishes the last pixel of the row before, before the window shifts.
		if (rx == 0 && s >= lag) begin
			tail_patch[0] = win[c][1];
			tail_patch[1] = win[c][2];
			tail_patch[2] = '0;
			val = kernel_value(tail_patch, ry - 2, wd - 1, wd, ht);
			emit = 1'b1;
		end

		slot = int'(rx * 3 + c);
		up = row_older[slot];
		mid = row_newer[slot];
		row_older[slot] = mid;
		row_newer[slot] = smp;
		win[c][0] = win[c][1];
		win[c][1] = win[c][2];
		win[c][2][0] = up;
		win[c][2][1] = mid;
		win[c][2][2] = smp;

		if (rx > 0 && s >= lag) begin
			val = kernel_value(win[c], ry - 1, rx - 1, wd, ht);
			emit = 1'b1;
		end

		c++;
		if (c >= nch) begin
			c = 0;
			rx++;
			if (rx >= wd) begin
				rx = 0;
				ry++;
			end
		end
		col_pos = rx;
		row_pos = ry;
		chan_pos = c;

		if (emit) begin
			o = s - lag;
			due.filtered_value = val;
			due.frame_last = (o + 1 >= wd * ht * nch);
			expected_q.push_back(due);
			if (due.frame_last)
				restart_frame();
		end
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: filtered_value=%0d frame_last=%0b",
				got.filtered_value, got.frame_last);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got.filtered_value !== want.filtered_value) begin
			$error("filtered_value: expected %0d, got %0d", want.filtered_value, got.filtered_value);
			fail_count++;
		end
		if (got.frame_last !== want.frame_last) begin
			$error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
			fail_count++;
		end
	endfunction

	// Outputs are checked before this edge's input is predicted, so a stray result
	// cannot pair up with an expectation created in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (cfg_we)
				apply_setting(cfg_idx, cfg_data);
			if (in_valid && in_ready)
				filter_step(in_data);
			outstanding = expected_q.size();
		end
	end

endmodule

@@ tb/sv/tb_conv3x3_image_filter.sv @@
// Top of the 3x3 image convolution filter testbench: clock, reset, stimulus and verdict.
// Depends on cif_pkg, the conv3x3_image_filter RTL and cif_filter_checker.
`timescale 1ns / 100ps

module tb_conv3x3_image_filter;
	import cif_pkg::*;

	localparam int TARGET_ITEMS = 1800;
	localparam int QUIET_ITEMS = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_NS = 4000000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, outstanding, checked;
	int gap_pct, stall_pct;
	int n_push, n_drain, n_counted, n_settings, widest;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	conv3x3_image_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	cif_filter_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	// Output back-pressure: random stalls at a rate set per phase.
	initial begin : ready_driver
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if ($urandom_range(1, 100) <= stall_pct) begin
				hold = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#WATCHDOG_NS;
		$display("watchdog expired with %0d results outstanding", outstanding);
		$display("tb_conv3x3_image_filter: done, errors");
		$finish;
	end

	// Called and returns at a falling edge; the transaction completes at the last rising edge between.
	task automatic feed_item(input logic req, input logic [FIELD_BITS-1:0] value);
		int gap;
		if ($urandom_range(1, 100) <= gap_pct) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {req, value};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (req == REQ_PUSH)
			n_push++;
		else
			n_drain++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	// Unused upper data bits carry noise; only the register's own width must count.
	task automatic load_settings(input int w, h, mx, fm, cm);
		write_reg(CFG_FRAME_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
		write_reg(CFG_FRAME_HEIGHT, {3'($urandom_range(0, 7)), 13'(h)});
		write_reg(CFG_MAX_VALUE, 16'(mx));
		write_reg(CFG_FILTER_MODE, {14'($urandom), 2'(fm)});
		write_reg(CFG_COLOR_MODE, {15'($urandom), 1'(cm)});
		cfg_we <= 1'b0;
		n_settings++;
		if (w > widest)
			widest = w;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [FIELD_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return FIELD_BITS'($urandom_range(0, 300));
			default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	function automatic int eff_width(int w);
		return (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
	endfunction

	// One frame of pushes, then unless cut short the drains that flush its tail. Drains inside the
	// frame, pushes after it and drains after the closing result are all ignored.
	task automatic run_frame(input int w, h, ch, input logic cut_short);
		int total, stop, k;
		total = w * h * ch;
		stop = cut_short ? $urandom_range(1, total) : total;
		for (k = 0; k < stop; k++) begin
			if ($urandom_range(0, 39) == 0)
				feed_item(REQ_DRAIN, FIELD_BITS'($urandom));
			feed_item(REQ_PUSH, pick_sample());
		end
		n_counted += stop;
		if (!cut_short) begin
			if ($urandom_range(0, 3) == 0)
				feed_item(REQ_PUSH, pick_sample());
			for (k = 0; k < (w + 1) * ch; k++)
				feed_item(REQ_DRAIN, FIELD_BITS'($urandom));
			n_counted += (w + 1) * ch;
			if ($urandom_range(0, 3) == 0)
				feed_item(REQ_DRAIN, FIELD_BITS'($urandom));
		end
	endtask

	task automatic run_phase(input int w, h, mx, fm, cm, frames, input logic cut_last);
		int f;
		load_settings(w, h, mx, fm, cm);
		for (f = 0; f < frames; f++)
			run_frame(eff_width(w), (h == 0) ? 1 : h, cm ? 3 : 1, cut_last && f == frames - 1);
		settle();
	endtask

	initial begin : stimulus
		int k, w, h, mx;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// 3x3 gray sharpen on a checkerboard of full-scale and zero samples.
		load_settings(3, 3, 65535, MODE_SHARPEN, 0);
		feed_item(REQ_DRAIN, '1);
		for (k = 0; k < 9; k++)
			feed_item(REQ_PUSH, (k % 2) ? '0 : '1);
		feed_item(REQ_PUSH, 16'h1234);
		for (k = 0; k < 4; k++)
			feed_item(REQ_DRAIN, '0);
		settle();

		// Zero width and height fold to a single RGB pixel; a zero ceiling clamps all.
		load_settings(0, 0, 0, MODE_LAPLACE, 1);
		feed_item(REQ_PUSH, '1);
		feed_item(REQ_PUSH, 16'h0001);
		feed_item(REQ_PUSH, 16'h8000);
		for (k = 0; k < 6; k++)
			feed_item(REQ_DRAIN, '1);
		settle();

		// Oversized width folds to the 2048-pixel maximum; the start of a row is abandoned.
		gap_pct = 8;
		stall_pct = 8;
		load_settings(4095, 1, 65535, MODE_BLUR, 0);
		repeat (24) feed_item(REQ_PUSH, pick_sample());
		settle();

		// Tallest frame, abandoned after a few rows; the next write restarts it.
		load_settings(1, 8191, 255, MODE_SHARPEN, 0);
		repeat (24) feed_item(REQ_PUSH, pick_sample());
		settle();

		// The random budget below counts only the small frames.
		n_counted = 0;
		while (n_counted < TARGET_ITEMS) begin
			if (n_counted >= TARGET_ITEMS - QUIET_ITEMS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 8 : 30);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 8 : 30);
			end
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = 1;
				2: w = $urandom_range(9, 40);
				default: w = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 7))
				0: h = 0;
				1: h = 1;
				default: h = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 7))
				0: mx = 0;
				1: mx = 1;
				2: mx = 65535;
				3, 4: mx = 255;
				5: mx = $urandom_range(0, 65535);
				default: mx = $urandom_range(100, 1000);
			endcase
			run_phase(w, h, mx, $urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(1, 2),
				$urandom_range(0, 7) == 0);
		end

		$display("covered %0d pushed samples and %0d drain requests over %0d register settings",
			n_push, n_drain, n_settings);
		$display("%0d filtered results compared, frame widths written up to %0d", checked, widest);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_conv3x3_image_filter: done, clean");
		else
			$display("tb_conv3x3_image_filter: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cif_pkg.sv
rtl/cif_line_store.sv
rtl/cif_window.sv
rtl/cif_kernel.sv
rtl/conv3x3_image_filter.sv
tb/sv/cif_filter_checker.sv
tb/sv/tb_conv3x3_image_filter.sv
